// ===== rtl/rans_byte_encoder_core_macros.svh =====
// assertion macros for the rans byte encoder core
`ifndef RANS_BYTE_ENCODER_CORE_MACROS_SVH
`define RANS_BYTE_ENCODER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define RBE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbe assertion failed");

// antecedent implies consequent in the following cycle
`define RBE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rbe assertion failed");

`else

`define RBE_ASSERT_SAME(lbl, ante, cons)
`define RBE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/rbe_pkg.sv =====
// types and constants shared by the rans byte encoder core
`timescale 1ns / 1ps

package rbe_pkg;

	// request codes
	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_ENCODE = 2'd1;
	localparam logic [1:0] REQ_FLUSH  = 2'd2;

	// result status codes
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_ZERO_FREQ = 1'b1;

	localparam int StateW = 31;
	localparam int FieldW = 13;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [FieldW-1:0] freq_value;
		logic [7:0]        symbol;
	} rbe_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       status;
		logic       last_of_run;
	} rbe_res_t;

	// one symbol table entry
	typedef struct packed {
		logic [FieldW-1:0] freq;
		logic [FieldW-1:0] start;
	} rbe_entry_t;

endpackage

// ===== rtl/rans_byte_encoder_core.sv =====
// top level of the single-state rans byte encoder
`timescale 1ns / 1ps

// Single-state rANS encoder with byte-wise renormalization. A load transaction
// (req_type 0) writes the next symbol's frequency into the table in symbol order;
// the running cumulative start is stored next to it, and after the last symbol
// the load pointer and sum return to zero. An encode transaction (req_type 1,
// symbols supplied last to first) reads the table entry, emits one low state
// byte per cycle, unless the output side stalls, while the state is at or above
// freq << (LOWER_BOUND_LOG - FREQ_BITS + 8), then divides the state by freq on a
// restoring divider that resolves one quotient bit per cycle. With
// K = LOWER_BOUND_LOG - FREQ_BITS + 8 (19 at the defaults), the quotient has K
// bits and an encode emits at most two bytes. A symbol with zero frequency, or
// beyond the alphabet, returns one result with status 1 and leaves the state
// alone. A flush (req_type 2) returns the four state bytes high byte first and
// reloads the state with 2^LOWER_BOUND_LOG. Bytes come out in generation order;
// the host reverses the stream. req_type 3 is dropped. The symbol table has no
// reset: encoding a symbol that was never loaded returns undefined data.
// req_ready is high only while the block is idle.

`include "rans_byte_encoder_core_macros.svh"

module rans_byte_encoder_core #(
	parameter int ALPHABET_SIZE   = 256,
	parameter int FREQ_BITS       = 12,
	parameter int LOWER_BOUND_LOG = 23
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  rbe_pkg::rbe_req_t req,
	output logic              res_valid,
	input  logic              res_ready,
	output rbe_pkg::rbe_res_t res
);

	import rbe_pkg::*;

	// quotient bits needed once the state is below the renorm bound
	localparam int K      = LOWER_BOUND_LOG - FREQ_BITS + 8;
	localparam int UpW    = FieldW + K;
	localparam int CmpW   = (UpW > StateW) ? UpW : StateW;
	localparam int IdxW   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int CntW   = $clog2(K + 1);
	localparam logic [StateW-1:0] InitState = StateW'(64'd1 << LOWER_BOUND_LOG);
	localparam logic [8:0]        AlphaLim  = 9'(ALPHABET_SIZE);
	localparam logic [IdxW-1:0]   LastIdx   = IdxW'(ALPHABET_SIZE - 1);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_READ   = 7'b0000010,
		ST_RENORM = 7'b0000100,
		ST_DIV    = 7'b0001000,
		ST_FIN    = 7'b0010000,
		ST_FLUSH  = 7'b0100000,
		ST_ERR    = 7'b1000000
	} rbe_state_t;

	rbe_state_t state_q;

	// symbol table, no reset
	rbe_entry_t table_mem [ALPHABET_SIZE];
	rbe_entry_t rd_q;

	logic [StateW-1:0] coder_state_q;
	logic [IdxW-1:0]   load_idx_q;
	logic [FieldW-1:0] sum_q;

	// encode working registers
	logic [StateW-1:0] x_q;
	logic [FieldW-1:0] f_q;
	logic [FieldW-1:0] st_q;
	logic              ge_q;
	logic [FieldW-1:0] rem_q;
	logic [K-1:0]      dq_q;
	logic [CntW-1:0]   div_cnt_q;
	logic [1:0]        fl_cnt_q;

	// output register
	logic     res_valid_q;
	rbe_res_t res_q;

	logic          accept;
	logic          slot_free;
	logic          sym_in_range;
	logic          tbl_we;
	logic [CmpW-1:0] cmp_a;
	logic [CmpW-1:0] cmp_b;
	logic            ge_now;
	logic [FieldW:0] r2;
	logic [FieldW:0] r2_sub;
	logic            sub_ok;
	logic [31:0]     fl_word;
	logic            emit;
	rbe_res_t        emit_data;

	assign req_ready    = (state_q == ST_IDLE);
	assign accept       = req_valid && req_ready;
	assign slot_free    = !res_valid_q || res_ready;
	assign sym_in_range = ({1'b0, req.symbol} < AlphaLim);
	assign tbl_we       = accept && (req.req_type == REQ_LOAD);
	assign res_valid    = res_valid_q;
	assign res          = res_q;

	// shared compare: bound check of the incoming state in READ, of the shifted
	// state in RENORM
	always_comb begin
		if (state_q == ST_READ) begin
			cmp_a = CmpW'(coder_state_q);
			cmp_b = CmpW'(rd_q.freq) << K;
		end else begin
			cmp_a = CmpW'(x_q >> 8);
			cmp_b = CmpW'(f_q) << K;
		end
		ge_now = (cmp_a >= cmp_b);
	end

	// one restoring division step
	always_comb begin
		r2     = {rem_q, dq_q[K-1]};
		sub_ok = (r2 >= {1'b0, f_q});
		r2_sub = r2 - {1'b0, f_q};
	end

	assign fl_word = {1'b0, coder_state_q};

	// result produced this cycle
	always_comb begin
		emit      = 1'b0;
		emit_data = '0;
		unique case (state_q)
			ST_RENORM: begin
				if (ge_q && slot_free) begin
					emit                  = 1'b1;
					emit_data.out_byte    = x_q[7:0];
					emit_data.status      = STATUS_OK;
					emit_data.last_of_run = !ge_now;
				end
			end
			ST_FLUSH: begin
				if (slot_free) begin
					emit               = 1'b1;
					emit_data.status   = STATUS_OK;
					unique case (fl_cnt_q)
						2'd0:    emit_data.out_byte = fl_word[31:24];
						2'd1:    emit_data.out_byte = fl_word[23:16];
						2'd2:    emit_data.out_byte = fl_word[15:8];
						default: emit_data.out_byte = fl_word[7:0];
					endcase
					emit_data.last_of_run = (fl_cnt_q == 2'd3);
				end
			end
			ST_ERR: begin
				if (slot_free) begin
					emit                  = 1'b1;
					emit_data.out_byte    = 8'h00;
					emit_data.status      = STATUS_ZERO_FREQ;
					emit_data.last_of_run = 1'b1;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// table write on load, registered read on encode
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			table_mem[load_idx_q] <= '{freq: req.freq_value, start: sum_q};
		end
		if (accept && (req.req_type == REQ_ENCODE)) begin
			rd_q <= table_mem[req.symbol[IdxW-1:0]];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= emit_data;
		end
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			coder_state_q <= InitState;
			load_idx_q    <= '0;
			sum_q         <= '0;
			ge_q          <= 1'b0;
			div_cnt_q     <= '0;
			fl_cnt_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.req_type)
							REQ_LOAD: begin
								if (load_idx_q == LastIdx) begin
									load_idx_q <= '0;
									sum_q      <= '0;
								end else begin
									load_idx_q <= load_idx_q + 1'b1;
									sum_q      <= sum_q + req.freq_value;
								end
							end
							REQ_ENCODE: begin
								state_q <= sym_in_range ? ST_READ : ST_ERR;
							end
							REQ_FLUSH: begin
								fl_cnt_q <= 2'd0;
								state_q  <= ST_FLUSH;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_READ: begin
					f_q  <= rd_q.freq;
					st_q <= rd_q.start;
					x_q  <= coder_state_q;
					ge_q <= ge_now;
					state_q <= (rd_q.freq == '0) ? ST_ERR : ST_RENORM;
				end
				ST_RENORM: begin
					if (ge_q) begin
						if (slot_free) begin
							x_q  <= x_q >> 8;
							ge_q <= ge_now;
						end
					end else begin
						// state now below f << K, so the quotient fits in K bits
						rem_q     <= FieldW'(x_q >> K);
						dq_q      <= x_q[K-1:0];
						div_cnt_q <= CntW'(K - 1);
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q     <= sub_ok ? r2_sub[FieldW-1:0] : r2[FieldW-1:0];
					dq_q      <= {dq_q[K-2:0], sub_ok};
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					coder_state_q <= (StateW'(dq_q) << FREQ_BITS) + StateW'(rem_q)
						+ StateW'(st_q);
					state_q <= ST_IDLE;
				end
				ST_FLUSH: begin
					if (slot_free) begin
						fl_cnt_q <= fl_cnt_q + 1'b1;
						if (fl_cnt_q == 2'd3) begin
							coder_state_q <= InitState;
							state_q       <= ST_IDLE;
						end
					end
				end
				ST_ERR: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// partial remainder always stays below the divisor
	`RBE_ASSERT_SAME(a_rem_below_freq, state_q == ST_DIV, rem_q < f_q)
	// an error result is a single zero byte that closes its run
	`RBE_ASSERT_SAME(a_err_single, res_valid_q && res_q.status,
		res_q.last_of_run && (res_q.out_byte == 8'h00))
	// a finished flush reloads the initial state
	`RBE_ASSERT_NEXT(a_flush_reinit, (state_q == ST_FLUSH) && slot_free && (fl_cnt_q == 2'd3),
		(coder_state_q == InitState) && (state_q == ST_IDLE))
	// renorm leaves the state below the bound before the divider starts
	`RBE_ASSERT_SAME(a_div_bound, (state_q == ST_RENORM) && !ge_q,
		(CmpW'(x_q) < (CmpW'(f_q) << K)))

endmodule

// ===== tb/rans_byte_encoder_core_test.sv =====
// self-checking testbench for the rans byte encoder core: directed corners, then random messages
`timescale 1ns / 1ps

module rans_byte_encoder_core_test;
	import rbe_pkg::*;

	localparam int ALPHA         = 256;
	localparam int FREQ_BITS     = 12;
	localparam int LB_LOG        = 23;
	localparam int RENORM_SHIFT  = LB_LOG - FREQ_BITS + 8;
	localparam int ITEM_TARGET   = 60;
	localparam int CALM_ITEMS    = 15;
	localparam int SETTLE_CYCLES = 64;
	localparam int MAX_PRINTS    = 40;
	localparam int FREQ_MAX      = 1 << FREQ_BITS;

	// request code the block drops without any effect
	localparam logic [1:0] REQ_DROPPED = 2'd3;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	rbe_req_t req       = '0;
	logic     res_valid;
	logic     res_ready = 1'b0;
	rbe_res_t res;

	// knobs for back-pressure on either side
	bit sender_gaps = 1'b0;
	bit stall_on    = 1'b0;
	int stall_left  = 0;

	// mirror of the encoder state
	logic [StateW-1:0] coder_x  = StateW'(1) << LB_LOG;
	logic [FieldW-1:0] freq_tab  [ALPHA];
	logic [FieldW-1:0] start_tab [ALPHA];
	bit                entry_loaded [ALPHA];
	logic [7:0]        load_ptr = '0;
	logic [FieldW-1:0] cum_sum  = '0;

	// coded bytes still owed by the block, oldest first
	rbe_res_t pending_bytes [$];

	int err_count     = 0;
	int bytes_checked = 0;
	int n_loads       = 0;
	int n_encodes     = 0;
	int n_quiet       = 0;
	int n_double      = 0;
	int n_zero_freq   = 0;
	int n_flushes     = 0;
	int n_dropped     = 0;

	rans_byte_encoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	function automatic void expect_byte(input logic [7:0] b, input logic st, input logic last);
		pending_bytes.push_back('{out_byte: b, status: st, last_of_run: last});
	endfunction

	// update the mirrored state for one accepted transaction and queue its bytes
	task automatic predict_request(input rbe_req_t item);
		logic [63:0] x;
		logic [63:0] f;
		logic [63:0] st;
		logic [63:0] bound;
		int          nbytes;
		bit          last;
		case (item.req_type)
			REQ_LOAD: begin
				n_loads++;
				freq_tab[load_ptr]     = item.freq_value;
				start_tab[load_ptr]    = cum_sum;
				entry_loaded[load_ptr] = 1'b1;
				// table full: pointer and sum start over
				if (load_ptr == 8'(ALPHA - 1)) begin
					load_ptr = '0;
					cum_sum  = '0;
				end else begin
					load_ptr = load_ptr + 8'd1;
					cum_sum  = cum_sum + item.freq_value;
				end
			end
			REQ_ENCODE: begin
				n_encodes++;
				f  = 64'(freq_tab[item.symbol]);
				st = 64'(start_tab[item.symbol]);
				if (f == 0) begin
					n_zero_freq++;
					expect_byte(8'h00, STATUS_ZERO_FREQ, 1'b1);
				end else begin
					x      = 64'(coder_x);
					bound  = f << RENORM_SHIFT;
					nbytes = 0;
					while (x >= bound && nbytes < 4) begin
						last = ((x >> 8) < bound) || (nbytes == 3);
						expect_byte(x[7:0], STATUS_OK, last);
						nbytes++;
						x = x >> 8;
					end
					if (nbytes == 0)
						n_quiet++;
					else if (nbytes > 1)
						n_double++;
					// wraps to the state width when the table is oversubscribed
					x       = ((x / f) << FREQ_BITS) + (x % f) + st;
					coder_x = x[StateW-1:0];
				end
			end
			REQ_FLUSH: begin
				n_flushes++;
				expect_byte({1'b0, coder_x[30:24]}, STATUS_OK, 1'b0);
				expect_byte(coder_x[23:16], STATUS_OK, 1'b0);
				expect_byte(coder_x[15:8], STATUS_OK, 1'b0);
				expect_byte(coder_x[7:0], STATUS_OK, 1'b1);
				coder_x = StateW'(1) << LB_LOG;
			end
			default: n_dropped++;
		endcase
	endtask

	// one request transaction; valid is only lowered when a gap begins
	task automatic send_request(input logic [1:0] kind, input logic [FieldW-1:0] fv,
			input logic [7:0] sym);
		rbe_req_t item;
		int       gap;
		item.req_type   = kind;
		item.freq_value = fv;
		item.symbol     = sym;
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predict_request(item);
	endtask

	// hold off the sender until every owed byte has come back
	task automatic wait_for_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_bytes.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_symbol(input bit nonzero_only);
		logic [7:0] sym;
		sym = 8'($urandom_range(0, ALPHA - 1));
		for (int tries = 0; tries < 400; tries++) begin
			if (entry_loaded[sym] && (!nonzero_only || freq_tab[sym] != 0))
				return sym;
			sym = 8'($urandom_range(0, ALPHA - 1));
		end
		// every entry is loaded by the time this is used, so symbol 0 is safe
		return 8'd0;
	endfunction

	// result side: random stall bursts and the byte-by-byte comparison
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else if (stall_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 16) - 1;
			res_ready <= 1'b0;
		end else
			res_ready <= 1'b1;
	end

	always @(posedge clk) begin : result_check
		rbe_res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_bytes.size() == 0)
				report_mismatch($sformatf("unexpected result byte %02h status %0b last %0b",
					res.out_byte, res.status, res.last_of_run));
			else begin
				want = pending_bytes.pop_front();
				bytes_checked++;
				if (res.out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte %02h, wanted %02h",
						res.out_byte, want.out_byte));
				if (res.status !== want.status)
					report_mismatch($sformatf("status %0b, wanted %0b",
						res.status, want.status));
				if (res.last_of_run !== want.last_of_run)
					report_mismatch($sformatf("last_of_run %0b, wanted %0b",
						res.last_of_run, want.last_of_run));
			end
		end
	end

	// flush straight out of reset and a dropped request with every field bit set
	task automatic test_flush_and_drop();
		sender_gaps = 1'b0;
		stall_on    = 1'b1;
		send_request(REQ_FLUSH, 13'($urandom_range(0, FREQ_MAX)), 8'($urandom));
		send_request(REQ_DROPPED, 13'h1FFF, 8'hFF);
		send_request(REQ_FLUSH, 13'h0000, 8'h00);
	endtask

	// oversubscribed table loaded to the end, then a few loads that start over
	task automatic test_table_wrap();
		logic [FieldW-1:0] fv;
		sender_gaps = 1'b1;
		stall_on    = 1'b0;
		for (int s = 0; s < ALPHA; s++) begin
			case (s)
				0:       fv = 13'd1;
				1:       fv = 13'd0;
				2:       fv = 13'(FREQ_MAX);
				3:       fv = 13'(FREQ_MAX - 1);
				254:     fv = 13'd7;
				255:     fv = 13'(FREQ_MAX);
				default: fv = 13'($urandom_range(0, 40));
			endcase
			send_request(REQ_LOAD, fv, 8'($urandom));
		end
		send_request(REQ_LOAD, 13'd2, 8'($urandom));
		send_request(REQ_LOAD, 13'd0, 8'($urandom));
		send_request(REQ_LOAD, 13'(FREQ_MAX), 8'($urandom));
	endtask

	// quiet encode, one and two byte renormalization, zero frequency, edge symbols
	task automatic test_encode_corners();
		sender_gaps = 1'b1;
		stall_on    = 1'b1;
		send_request(REQ_ENCODE, 13'($urandom_range(0, FREQ_MAX)), 8'd3);
		send_request(REQ_ENCODE, 13'($urandom_range(0, FREQ_MAX)), 8'd0);
		send_request(REQ_ENCODE, 13'($urandom_range(0, FREQ_MAX)), 8'd0);
		send_request(REQ_ENCODE, 13'($urandom_range(0, FREQ_MAX)), 8'd0);
		send_request(REQ_ENCODE, 13'($urandom_range(0, FREQ_MAX)), 8'd1);
		send_request(REQ_ENCODE, 13'h1FFF, 8'd255);
		send_request(REQ_ENCODE, 13'($urandom_range(0, FREQ_MAX)), 8'd254);
		send_request(REQ_ENCODE, 13'($urandom_range(0, FREQ_MAX)), 8'd2);
		send_request(REQ_FLUSH, 13'h1FFF, 8'hFF);
		send_request(REQ_ENCODE, 13'($urandom_range(0, FREQ_MAX)), 8'd0);
		send_request(REQ_ENCODE, 13'($urandom_range(0, FREQ_MAX)), 8'd1);
		send_request(REQ_FLUSH, 13'($urandom_range(0, FREQ_MAX)), 8'($urandom));
	endtask

	// messages of encodes closed by a flush, over the table already loaded
	task automatic test_random_messages();
		int unsigned sent;
		int unsigned msg_len;
		int unsigned roll;
		bit          drained;
		bit          calm;
		sent    = 0;
		drained = 1'b0;
		while (sent < ITEM_TARGET) begin
			calm        = sent >= ITEM_TARGET - CALM_ITEMS;
			sender_gaps = !calm && $urandom_range(0, 3) != 0;
			stall_on    = !calm && $urandom_range(0, 3) != 0;
			if (!drained && sent >= ITEM_TARGET / 2) begin
				wait_for_results();
				drained = 1'b1;
			end
			msg_len = $urandom_range(1, 12);
			repeat (msg_len) begin
				roll = $urandom_range(0, 99);
				if (roll < 80)
					send_request(REQ_ENCODE, 13'($urandom_range(0, FREQ_MAX)), pick_symbol(1'b1));
				else if (roll < 88)
					send_request(REQ_ENCODE, 13'($urandom_range(0, FREQ_MAX)), pick_symbol(1'b0));
				else if (roll < 92)
					send_request(REQ_LOAD, 13'($urandom_range(0, FREQ_MAX)), 8'($urandom));
				else if (roll < 96)
					send_request(REQ_DROPPED, 13'($urandom_range(0, 8191)), 8'($urandom));
				else
					send_request(REQ_FLUSH, 13'($urandom_range(0, FREQ_MAX)), 8'($urandom));
				if (roll < 92 || roll >= 96)
					sent++;
			end
			// most messages close with a flush, a few are left open
			if ($urandom_range(0, 9) != 0) begin
				send_request(REQ_FLUSH, 13'($urandom_range(0, FREQ_MAX)), 8'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_flush_and_drop();
		test_table_wrap();
		test_encode_corners();
		test_random_messages();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d loads, %0d encodes (%0d without output, %0d two-byte, %0d zero-freq)",
			n_loads, n_encodes, n_quiet, n_double, n_zero_freq);
		$display("covered %0d flushes, %0d dropped requests; %0d result transactions compared",
			n_flushes, n_dropped, bytes_checked);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("watchdog expired with %0d results outstanding", pending_bytes.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
